### src/hhpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue histogram peak finder package
// Command codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package hhpf_pkg;

  // Fixed field widths
  localparam int CMD_BITS    = 2;
  localparam int HUE_BITS    = 8;
  localparam int SCALE_BITS  = 10;
  localparam int HEIGHT_BITS = 10;

  // Scale register value after reset
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 10'd399;

  // Item commands; the fourth code is ignored
  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

### src/hue_histogram_peak_finder.sv
`timescale 1ns / 1ps
// Add items: one accepted per cycle while idle, written back in the next cycle (read-modify-write).
// Query items: three bin reads, each scaled and divided by one shared divider
//   that resolves one quotient bit per cycle, then a registered result.
// Clear items and reset: a sweep over every bin zeroes the count memory;
//   no item is accepted during the sweep. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// Hue histogram peak finder
// Counts hues into a bin memory with saturating counts and a running maximum,
// and answers bin queries with count, normalized height and a peak flag.
// ----------------------------------------------------------------------------
module hue_histogram_peak_finder #(
  parameter int NUM_BINS   = 181,
  parameter int COUNT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  // Scale register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hhpf_pkg::SCALE_BITS-1:0]     cfg_data,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*hhpf_pkg::HUE_BITS-1:0]     s_axis_tdata,  // hue, bin_index
  input  logic [hhpf_pkg::CMD_BITS-1:0]       s_axis_tuser,  // command
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((COUNT_BITS + hhpf_pkg::HEIGHT_BITS + 1 + 7) / 8) * 8 - 1:0]
                                              m_axis_tdata,  // raw_count, height, is_peak
  output logic                                m_axis_tuser   // status
);

  import hhpf_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int XW = ((AW > HUE_BITS) ? AW : HUE_BITS) + 1;
  localparam int OW = ((COUNT_BITS + HEIGHT_BITS + 1 + 7) / 8) * 8;
  localparam int PW = COUNT_BITS + SCALE_BITS;

  // Controller
  state_t state, state_next;

  // Configuration
  logic [SCALE_BITS-1:0] scale_top;

  // Count memory ports
  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_data;

  // Input decode
  logic                  in_fire;
  cmd_t                  in_cmd;
  logic [XW-1:0]         hue_x;
  logic                  hue_in_range;

  // Add stage and write forwarding
  logic                  add_valid;
  logic [AW-1:0]         add_addr;
  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] inc_count;
  logic [COUNT_BITS-1:0] largest;

  // Clearing sweep
  logic [AW-1:0]         clr_addr;

  // Query path
  logic [HUE_BITS-1:0]   q_idx;
  logic                  q_empty;
  logic [1:0]            tap;
  logic [XW-1:0]         tap_addr_x;
  logic                  tap_in_range;
  logic                  rd_in_range;
  logic [COUNT_BITS-1:0] raw_q;
  logic [PW-1:0]         prod;
  logic [SCALE_BITS-1:0] prod_lo;
  logic [3:0]            div_step;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] rem_cur;
  logic [COUNT_BITS:0]   trial;
  logic                  trial_ge;
  logic [HEIGHT_BITS-1:0] quo;
  logic [HEIGHT_BITS-1:0] hts [3];
  logic                  center_in_range;
  logic                  center_last;
  logic                  peak;
  logic [OW-1:0]         tdata_next;

  // Input decode
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign in_cmd       = cmd_t'(s_axis_tuser);
  assign hue_x        = XW'(s_axis_tdata[HUE_BITS-1:0]);
  assign hue_in_range = hue_x < XW'(NUM_BINS);

  // Configuration write, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_top <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_top <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(NUM_BINS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_QUERY: state_next = ST_READ;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_step == 4'(HEIGHT_BITS - 1)) begin
          state_next = (tap == 2'd2) ? ST_OUT : ST_READ;
        end
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs: handshake and memory ports
  always_comb begin
    s_axis_tready = 1'b0;
    rd_addr       = hue_x[AW-1:0];
    wr_en         = add_valid;
    wr_addr       = add_addr;
    wr_data       = inc_count;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_READ: begin
        rd_addr = tap_addr_x[AW-1:0];
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Count memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Add stage: forward the previous write when it hits the same bin
  assign cur_count = (fwd_valid && fwd_addr == add_addr) ? fwd_data : rd_data;
  assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      add_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      add_valid <= in_fire && in_cmd == CMD_ADD && hue_in_range;
      fwd_valid <= add_valid;
    end
    add_addr <= hue_x[AW-1:0];
    fwd_addr <= add_addr;
    fwd_data <= inc_count;
  end

  // Running maximum, dropped by a clear item
  always_ff @(posedge clk) begin
    if (rst) begin
      largest <= '0;
    end else if (in_fire && in_cmd == CMD_CLEAR) begin
      largest <= '0;
    end else if (add_valid && inc_count > largest) begin
      largest <= inc_count;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end else begin
      clr_addr <= '0;
    end
  end

  // Query taps: left neighbor, center, right neighbor
  assign tap_addr_x   = XW'(q_idx) + XW'(tap) - XW'(1);
  assign tap_in_range = tap_addr_x < XW'(NUM_BINS);

  // Divider step: one quotient bit per cycle
  assign prod_lo  = prod[SCALE_BITS-1:0];
  assign rem_cur  = (div_step == 4'd0) ? prod[PW-1:SCALE_BITS] : rem;
  assign trial    = {rem_cur, prod_lo[4'(SCALE_BITS - 1) - div_step]};
  assign trial_ge = trial >= {1'b0, largest};

  always_ff @(posedge clk) begin
    if (rst) begin
      tap      <= '0;
      div_step <= '0;
    end else begin
      if (state == ST_IDLE) begin
        tap      <= '0;
        div_step <= '0;
      end else if (state == ST_DIV) begin
        if (div_step == 4'(HEIGHT_BITS - 1)) begin
          div_step <= '0;
          tap      <= tap + 2'd1;
        end else begin
          div_step <= div_step + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    // Capture the query
    if (state == ST_IDLE && in_fire) begin
      q_idx   <= s_axis_tdata[2*HUE_BITS-1:HUE_BITS];
      q_empty <= largest == '0 && !add_valid;
    end
    // Note whether the tap hits a bin
    if (state == ST_READ) begin
      rd_in_range <= tap_in_range;
    end
    // Scale the count; keep the center count
    if (state == ST_MUL) begin
      prod <= PW'(rd_in_range ? rd_data : '0) * PW'(scale_top);
      if (tap == 2'd1) begin
        raw_q <= rd_in_range ? rd_data : '0;
      end
    end
    // Shift in quotient bits; store the height on the last one
    if (state == ST_DIV) begin
      rem <= trial_ge ? COUNT_BITS'(trial - {1'b0, largest}) : trial[COUNT_BITS-1:0];
      quo <= {quo[HEIGHT_BITS-2:0], trial_ge};
      if (div_step == 4'(HEIGHT_BITS - 1)) begin
        hts[tap] <= {quo[HEIGHT_BITS-2:0], trial_ge};
      end
    end
  end

  // Peak flag; a missing left neighbor reads as height zero
  assign center_in_range = XW'(q_idx) < XW'(NUM_BINS);
  assign center_last     = XW'(q_idx) == XW'(NUM_BINS - 1);
  assign peak = !q_empty && center_in_range && !center_last &&
                hts[1] > hts[0] && hts[1] > hts[2];

  always_comb begin
    tdata_next = '0;
    tdata_next[COUNT_BITS-1:0] = q_empty ? '0 : raw_q;
    tdata_next[COUNT_BITS +: HEIGHT_BITS] = (q_empty || !center_in_range) ? '0 : hts[1];
    tdata_next[COUNT_BITS + HEIGHT_BITS] = peak;
  end

  // Output register: load the result, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= tdata_next;
      m_axis_tuser <= q_empty;
    end
  end

`ifndef SYNTHESIS
  // No write may land while a query reads the memory
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_MUL || state == ST_DIV) |-> !wr_en)
    else $error("count memory written during a query");

  // The running maximum covers every count just written, unless cleared
  a_largest_covers: assert property (@(posedge clk) disable iff (rst)
    (add_valid && !(in_fire && in_cmd == CMD_CLEAR)) |=> largest >= $past(inc_count))
    else $error("running maximum below a written count");

  // The clearing sweep never overlaps an add write-back
  a_sweep_alone: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !add_valid)
    else $error("add write-back during clearing sweep");
`endif

endmodule

### verif/tb_hue_histogram_peak_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue histogram peak finder testbench
// Drives add, query, clear and unused-command items into the block under
// random input gaps and output stalls. A directed table covers the empty
// histogram, edge bins, out-of-range hues and indexes and the unused command.
// A gap-free burst hits neighboring bins back to back, and random images
// follow under several scale settings. Every query answer is checked field by
// field against an in-bench histogram predictor or a typed directed answer.
// ----------------------------------------------------------------------------
module tb_hue_histogram_peak_finder;
  import hhpf_pkg::*;

  localparam int NUM_BINS    = 181;
  localparam int COUNT_BITS  = 20;
  localparam int DATA_BITS   = ((COUNT_BITS + HEIGHT_BITS + 1 + 7) / 8) * 8;
  localparam int HEIGHT_LSB  = COUNT_BITS;
  localparam int PEAK_BIT    = COUNT_BITS + HEIGHT_BITS;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_WAIT  = 250;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  raw;
    logic [HEIGHT_BITS-1:0] height;
    logic                   peak;
    logic                   empty;
  } bin_answer_t;

  typedef struct {
    logic [CMD_BITS-1:0] cmd;
    logic [HUE_BITS-1:0] hue;
    logic [HUE_BITS-1:0] idx;
    bit                  typed;
    bin_answer_t         answer;
  } stim_row_t;

  // Block ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SCALE_BITS-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*HUE_BITS-1:0]  s_axis_tdata = '0;  // hue, bin_index
  logic [CMD_BITS-1:0]    s_axis_tuser = '0;  // command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0]   m_axis_tdata;       // raw_count, height, is_peak
  logic                   m_axis_tuser;       // status

  // Histogram predictor state
  logic [COUNT_BITS-1:0]  bin_count [NUM_BINS];
  bit                     bin_live  [NUM_BINS];
  logic [COUNT_BITS-1:0]  largest_count;
  logic [SCALE_BITS-1:0]  scale_top;

  bin_answer_t pending_answers [$];
  stim_row_t   directed_rows [$];

  int  errors = 0;
  int  answers_checked = 0;
  int  adds_sent = 0;
  int  queries_sent = 0;
  int  clears_sent = 0;
  int  ignored_sent = 0;
  int  scales_used = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;

  hue_histogram_peak_finder #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d answers outstanding", $time, cycle_count,
               pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Count stored in a bin; bins not written since the last clear read as zero
  function automatic logic [COUNT_BITS-1:0] count_of(input int b);
    if (b >= NUM_BINS || !bin_live[b]) return '0;
    return bin_count[b];
  endfunction

  // Normalized height of a bin under the current scale
  function automatic logic [HEIGHT_BITS-1:0] height_of(input int b);
    longint unsigned prod;
    if (largest_count == 0) return '0;
    prod = longint'(count_of(b)) * longint'(scale_top);
    return HEIGHT_BITS'(prod / longint'(largest_count));
  endfunction

  // Advance the histogram by one accepted item; flag an answer for queries
  task automatic histogram_step(input logic [CMD_BITS-1:0] cmd, input logic [HUE_BITS-1:0] hue,
                                input logic [HUE_BITS-1:0] idx, output bit has_answer,
                                output bin_answer_t ans);
    logic [COUNT_BITS-1:0]  c;
    logic [HEIGHT_BITS-1:0] h;
    int                     b;
    has_answer = 1'b0;
    ans = '0;
    b = int'(idx);
    if (cmd == CMD_ADD) begin
      if (int'(hue) < NUM_BINS) begin
        c = count_of(int'(hue));
        if (c != '1) c = c + 1'b1;
        bin_count[hue] = c;
        bin_live[hue] = 1'b1;
        if (c > largest_count) largest_count = c;
      end
    end else if (cmd == CMD_CLEAR) begin
      foreach (bin_live[i]) bin_live[i] = 1'b0;
      largest_count = '0;
    end else if (cmd == CMD_QUERY) begin
      has_answer = 1'b1;
      ans.empty = (largest_count == 0);
      if (!ans.empty && b < NUM_BINS) begin
        h = height_of(b);
        ans.raw = count_of(b);
        ans.height = h;
        if (b == 0) ans.peak = (h > height_of(1));
        else if (b < NUM_BINS - 1) ans.peak = (h > height_of(b - 1)) && (h > height_of(b + 1));
      end
    end
  endtask

  // Gap length for either side: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until accepted, then predict its answer
  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [HUE_BITS-1:0] hue,
                           input logic [HUE_BITS-1:0] idx, input bit typed,
                           input bin_answer_t typed_ans);
    bin_answer_t ans;
    bit          has_answer;
    int          g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, hue};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    histogram_step(cmd, hue, idx, has_answer, ans);
    if (has_answer) pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
    if (cmd == CMD_ADD && int'(hue) < NUM_BINS) adds_sent++;
    else if (cmd == CMD_QUERY) queries_sent++;
    else if (cmd == CMD_CLEAR) clears_sent++;
    else ignored_sent++;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_plain(input logic [CMD_BITS-1:0] cmd, input int hue, input int idx);
    send_item(cmd, HUE_BITS'(hue), HUE_BITS'(idx), 1'b0, '0);
  endtask

  // Drop valid and wait until every answer is in and any clear sweep is done
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the scale register while the block is idle
  task automatic write_scale(input logic [SCALE_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scale_top = v;
    scales_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [CMD_BITS-1:0] cmd, input int hue, input int idx,
                         input bit typed, input int raw, input int h, input bit pk,
                         input bit st);
    stim_row_t r;
    r.cmd = cmd;
    r.hue = HUE_BITS'(hue);
    r.idx = HUE_BITS'(idx);
    r.typed = typed;
    r.answer = '{raw: COUNT_BITS'(raw), height: HEIGHT_BITS'(h), peak: pk, empty: st};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Random images: usually a clear, clustered hues, then queries mostly around the clusters
  task automatic run_images(input int n_items);
    int counted;
    int n_cent;
    int centers [3];
    int n_adds;
    int n_q;
    int roll;
    int v;
    counted = 0;
    while (counted < n_items) begin
      if ($urandom_range(0, 5) != 0) begin
        send_plain(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
        counted++;
        if ($urandom_range(0, 7) == 0) begin
          send_plain(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 255));
          counted++;
        end
      end
      n_cent = $urandom_range(1, 3);
      foreach (centers[i]) begin
        roll = $urandom_range(0, 5);
        centers[i] = (roll == 0) ? 0 : (roll == 1) ? NUM_BINS - 1 : $urandom_range(0, 180);
      end
      n_adds = $urandom_range(4, 30);
      for (int k = 0; k < n_adds; k++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          send_plain(CMD_ADD, $urandom_range(NUM_BINS, 255), $urandom_range(0, 255));
        end else if (roll == 1) begin
          send_plain(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          if (roll == 2) begin
            v = $urandom_range(0, NUM_BINS - 1);
          end else begin
            v = centers[$urandom_range(0, n_cent - 1)] + $urandom_range(0, 8) - 4;
            if (v < 0) v = 0;
            if (v > NUM_BINS - 1) v = NUM_BINS - 1;
          end
          send_plain(CMD_ADD, v, $urandom_range(0, 255));
          counted++;
        end
      end
      n_q = $urandom_range(2, 6);
      for (int k = 0; k < n_q; k++) begin
        roll = $urandom_range(0, 9);
        if (roll < 5) v = centers[$urandom_range(0, n_cent - 1)] + $urandom_range(0, 2) - 1;
        else if (roll == 5) v = 0;
        else if (roll == 6) v = $urandom_range(NUM_BINS - 2, NUM_BINS - 1);
        else v = $urandom_range(0, 255);
        if (v < 0) v = 0;
        send_plain(CMD_QUERY, $urandom_range(0, 255), v);
        counted++;
      end
    end
  endtask

  // Receiver: random stalls, and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each answer with the oldest expectation
  always @(posedge clk) begin
    bin_answer_t got;
    bin_answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.raw    = m_axis_tdata[COUNT_BITS-1:0];
      got.height = m_axis_tdata[HEIGHT_LSB +: HEIGHT_BITS];
      got.peak   = m_axis_tdata[PEAK_BIT];
      got.empty  = m_axis_tuser;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer raw=%0d height=%0d peak=%0d status=%0d", $time,
                 got.raw, got.height, got.peak, got.empty);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (got != want) begin
          errors++;
          $display("%0t: answer mismatch expected raw=%0d height=%0d peak=%0d status=%0d",
                   $time, want.raw, want.height, want.peak, want.empty);
          $display("%0t:                 actual raw=%0d height=%0d peak=%0d status=%0d",
                   $time, got.raw, got.height, got.peak, got.empty);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [SCALE_BITS-1:0] phase_scale [6];
    foreach (bin_count[i]) bin_count[i] = '0;
    foreach (bin_live[i]) bin_live[i] = 1'b0;
    largest_count = '0;
    scale_top = SCALE_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty histogram, edge bins, ignored items, clear
    add_row(CMD_QUERY,   0,   0, 1,  0,   0, 0, 1);
    add_row(CMD_QUERY, 255, 255, 1,  0,   0, 0, 1);
    add_row(CMD_ADD,     0, 255, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,     0,   0, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,     1,   0, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0,   0, 1,  2, 399, 1, 0);
    add_row(CMD_QUERY,   0,   1, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,   180,   0, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,   180,   0, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,   180,   0, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0, 180, 1,  3, 399, 0, 0);
    add_row(CMD_ADD,   181,   0, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,   255,   0, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0, 181, 1,  0,   0, 0, 0);
    add_row(CMD_QUERY, 255, 255, 1,  0,   0, 0, 0);
    add_row(CMD_ADD,   179,   0, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0, 179, 0,  0,   0, 0, 0);
    add_row(CMD_UNUSED, 90,  90, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0,  90, 0,  0,   0, 0, 0);
    add_row(CMD_CLEAR,   0,   0, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,   0,   0, 1,  0,   0, 0, 1);
    add_row(CMD_ADD,    85,  85, 0,  0,   0, 0, 0);
    add_row(CMD_ADD,   170, 170, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY,  85,  85, 0,  0,   0, 0, 0);
    add_row(CMD_QUERY, 170, 170, 0,  0,   0, 0, 0);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].hue, directed_rows[i].idx,
                directed_rows[i].typed, directed_rows[i].answer);
    end
    drain();

    // Gap-free burst on neighboring bins at the widest scale
    write_scale(10'd1023);
    idle_on = 1'b0;
    send_plain(CMD_CLEAR, 0, 0);
    repeat (5) send_plain(CMD_ADD, 99, 0);
    repeat (10) send_plain(CMD_ADD, 100, 0);
    repeat (2) send_plain(CMD_ADD, 101, 0);
    send_plain(CMD_QUERY, 0, 99);
    send_plain(CMD_QUERY, 0, 100);
    send_plain(CMD_QUERY, 0, 101);
    send_plain(CMD_QUERY, 0, 0);
    idle_on = 1'b1;
    drain();

    // Random images under several scales, extremes and zero
    phase_scale = '{10'd1, 10'd1023, 10'd0, 10'd512,
                    SCALE_BITS'($urandom_range(2, 1022)), SCALE_RESET};
    foreach (phase_scale[p]) begin
      write_scale(phase_scale[p]);
      idle_on = (p != 1);
      if (p == 3) hold_request = 1'b1;
      run_images(PHASE_ITEMS);
      drain();
    end
    idle_on = 1'b1;

    if (pending_answers.size() != 0) begin
      errors++;
      $display("%0t: %0d expected answers never arrived", $time, pending_answers.size());
    end
    $display("Run covered %0d adds, %0d queries, %0d clears, %0d ignored items, %0d scales",
             adds_sent, queries_sent, clears_sent, ignored_sent, scales_used);
    $display("Checked %0d query answers, with a back-to-back burst on neighboring bins",
             answers_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
src/hhpf_pkg.sv
src/hue_histogram_peak_finder.sv
verif/tb_hue_histogram_peak_finder.sv
